>>> rtl/core/abkf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and constants of the angle / bias Kalman filter
// Word formats, controller-to-datapath command word, the step program of the
// sequencer and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package abkf_pkg;

   // fixed formats
   localparam int DT_FRAC   = 16;
   localparam int CFG_W     = 25;
   localparam int CSR_IDX_W = 2;

   // shared multiplier operand widths and the wide accumulation width
   localparam int OPA_W  = 36;
   localparam int OPB_W  = 33;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int WIDE_W = 72;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_Q_ANGLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_BIAS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_MEASURE = 2'd2;

   // reset values of the noise registers
   localparam logic [CFG_W-1:0] Q_ANGLE_RST   = 25'd16777;
   localparam logic [CFG_W-1:0] Q_BIAS_RST    = 25'd50332;
   localparam logic [CFG_W-1:0] R_MEASURE_RST = 25'd503316;

   typedef struct packed {
      logic signed [24:0] tilt_meas;
      logic signed [27:0] spin_rate;
      logic        [15:0] dt;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] angle_est;
      logic signed [31:0] bias_est;
   } rsp_word_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MUL, OP_UPD, OP_DP11, OP_INNER, OP_DIV, OP_GAIN, OP_EMIT
   } op_type;

   typedef enum logic [2:0] {SA_RATE, SA_P11, SA_INNER, SA_QB, SA_K0, SA_K1} srca_type;
   typedef enum logic [1:0] {SB_DT, SB_Y, SB_P00, SB_P01} srcb_type;
   typedef enum logic [2:0] {TG_ANGLE, TG_BIAS, TG_P00, TG_P01, TG_P10, TG_P11} tgt_type;

   typedef struct packed {
      op_type   op;
      srca_type a_sel;
      srcb_type b_sel;
      tgt_type  tgt;
      logic     cov_shift;  // round by the covariance fraction, else by dt's
      logic     sub;        // subtract the rounded product from the target
      logic     gain_sel;   // 0: K0 / P00, 1: K1 / P10
   } cmd_type;

   typedef struct packed {
      logic gain_ok;   // P00 plus the measurement noise is positive
      logic div_done;  // divider idle, quotient valid
      logic out_free;  // output register can take a word this cycle
   } stat_type;

   // sequencer program
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_LOAD = 5'd0;
   localparam logic [STEP_W-1:0] STEP_EMIT = 5'd26;

   function automatic cmd_type mk_cmd(input op_type op, input srca_type a, input srcb_type b,
                                      input tgt_type t, input logic cs, input logic sb,
                                      input logic g);
      cmd_type c;
      c.op        = op;
      c.a_sel     = a;
      c.b_sel     = b;
      c.tgt       = t;
      c.cov_shift = cs;
      c.sub       = sb;
      c.gain_sel  = g;
      return c;
   endfunction

   function automatic cmd_type prog_word(input logic [STEP_W-1:0] step);
      cmd_type c;
      c = mk_cmd(OP_NONE, SA_RATE, SB_DT, TG_ANGLE, 1'b0, 1'b0, 1'b0);
      case (step)
         // predict
         5'd0:  c = mk_cmd(OP_LOAD,  SA_RATE,  SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd1:  c = mk_cmd(OP_MUL,   SA_RATE,  SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd2:  c = mk_cmd(OP_UPD,   SA_RATE,  SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd3:  c = mk_cmd(OP_MUL,   SA_P11,   SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd4:  c = mk_cmd(OP_DP11,  SA_P11,   SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd5:  c = mk_cmd(OP_INNER, SA_P11,   SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd6:  c = mk_cmd(OP_MUL,   SA_INNER, SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd7:  c = mk_cmd(OP_UPD,   SA_INNER, SB_DT,  TG_P00,   1'b0, 1'b0, 1'b0);
         5'd8:  c = mk_cmd(OP_MUL,   SA_QB,    SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         5'd9:  c = mk_cmd(OP_UPD,   SA_QB,    SB_DT,  TG_P11,   1'b0, 1'b0, 1'b0);
         // gains
         5'd10: c = mk_cmd(OP_DIV,   SA_K0,    SB_Y,   TG_ANGLE, 1'b1, 1'b0, 1'b0);
         5'd11: c = mk_cmd(OP_GAIN,  SA_K0,    SB_Y,   TG_ANGLE, 1'b1, 1'b0, 1'b0);
         5'd12: c = mk_cmd(OP_DIV,   SA_K1,    SB_Y,   TG_ANGLE, 1'b1, 1'b0, 1'b1);
         5'd13: c = mk_cmd(OP_GAIN,  SA_K1,    SB_Y,   TG_ANGLE, 1'b1, 1'b0, 1'b1);
         // correct
         5'd14: c = mk_cmd(OP_MUL,   SA_K0,    SB_Y,   TG_ANGLE, 1'b1, 1'b0, 1'b0);
         5'd15: c = mk_cmd(OP_UPD,   SA_K0,    SB_Y,   TG_ANGLE, 1'b1, 1'b0, 1'b0);
         5'd16: c = mk_cmd(OP_MUL,   SA_K1,    SB_Y,   TG_BIAS,  1'b1, 1'b0, 1'b0);
         5'd17: c = mk_cmd(OP_UPD,   SA_K1,    SB_Y,   TG_BIAS,  1'b1, 1'b0, 1'b0);
         5'd18: c = mk_cmd(OP_MUL,   SA_K1,    SB_P00, TG_P10,   1'b1, 1'b1, 1'b0);
         5'd19: c = mk_cmd(OP_UPD,   SA_K1,    SB_P00, TG_P10,   1'b1, 1'b1, 1'b0);
         5'd20: c = mk_cmd(OP_MUL,   SA_K0,    SB_P00, TG_P00,   1'b1, 1'b1, 1'b0);
         5'd21: c = mk_cmd(OP_UPD,   SA_K0,    SB_P00, TG_P00,   1'b1, 1'b1, 1'b0);
         5'd22: c = mk_cmd(OP_MUL,   SA_K1,    SB_P01, TG_P11,   1'b1, 1'b1, 1'b0);
         5'd23: c = mk_cmd(OP_UPD,   SA_K1,    SB_P01, TG_P11,   1'b1, 1'b1, 1'b0);
         5'd24: c = mk_cmd(OP_MUL,   SA_K0,    SB_P01, TG_P01,   1'b1, 1'b1, 1'b0);
         5'd25: c = mk_cmd(OP_UPD,   SA_K0,    SB_P01, TG_P01,   1'b1, 1'b1, 1'b0);
         5'd26: c = mk_cmd(OP_EMIT,  SA_RATE,  SB_DT,  TG_ANGLE, 1'b0, 1'b0, 1'b0);
         default: c = mk_cmd(OP_NONE, SA_RATE, SB_DT, TG_ANGLE, 1'b0, 1'b0, 1'b0);
      endcase
      return c;
   endfunction

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v[WIDE_W-1:31] == '0 || v[WIDE_W-1:31] == '1) begin
         r = v[31:0];
      end else if (v[WIDE_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/abkf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_div: bit-serial gain divider
// Restoring division of (num << COV_FRAC_BITS) by a positive divisor, one
// quotient bit per cycle, truncated toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module abkf_div #(
   parameter int COV_FRAC_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic        [32:0] den,
   output      logic               busy,
   output      logic signed [31:0] quo
);
   import abkf_pkg::*;

   localparam int NUM_W = 32 + COV_FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [33:0]      rem_ff, rem_in;
   logic [32:0]      den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [31:0] num_mag;
   logic [33:0] rem_sh;
   logic [34:0] diff;
   logic        ge;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      num_mag = num[31] ? 32'(-num) : 32'(num);
      rem_sh  = {rem_ff[32:0], dvd_ff[NUM_W-1]};
      diff    = {1'b0, rem_sh} - 35'(den_ff);
      ge      = !diff[34];

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         dvd_in  = {num_mag, {COV_FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[31];
      end else if (busy_ff) begin
         rem_in = ge ? diff[33:0] : rem_sh;
         dvd_in = {dvd_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // apply sign and clamp the quotient
   always_comb begin
      if (!neg_ff) begin
         quo = (dvd_ff[NUM_W-1:32] != '0 || dvd_ff[31]) ? 32'sh7fff_ffff
                                                          : signed'(dvd_ff[31:0]);
      end else begin
         quo = (dvd_ff[NUM_W-1:32] != '0 || (dvd_ff[31] && dvd_ff[30:0] != '0))
               ? 32'sh8000_0000 : signed'(32'(-dvd_ff[31:0]));
      end
   end

   assign busy = busy_ff;

`ifndef ASSERT_OFF
   a_div_start_loads: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && cnt_ff == CNT_W'(NUM_W)))
      else $error("divider did not load on start");
`endif

endmodule
`default_nettype wire

>>> rtl/core/abkf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_dp: filter datapath
// Holds the noise registers, filter state and covariance, the shared
// multiplier with its product register, the gain divider and the output word.
// ----------------------------------------------------------------------------
module abkf_dp #(
   parameter int COV_FRAC_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [1:0]             csr_index,
   input  wire logic [24:0]            csr_wdata,
   input  wire abkf_pkg::req_word_type req_data,
   input  wire abkf_pkg::cmd_type      cmd,
   input  wire logic                   cmd_valid,
   output      abkf_pkg::stat_type     stat,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      abkf_pkg::rsp_word_type rsp_data
);
   import abkf_pkg::*;

   localparam logic signed [31:0]       COV_ONE  = 32'(2 ** COV_FRAC_BITS);
   localparam logic signed [WIDE_W-1:0] HALF_DT  = WIDE_W'(2 ** (DT_FRAC - 1));
   localparam logic signed [WIDE_W-1:0] HALF_COV = WIDE_W'(2 ** (COV_FRAC_BITS - 1));

   // configuration
   logic [CFG_W-1:0] qa_ff, qa_in, qb_ff, qb_in, r_ff, r_in;
   // filter state
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   // per-sample working registers
   logic signed [24:0]       accel_ff, accel_in;
   logic        [15:0]       dt_ff, dt_in;
   logic signed [31:0]       rate_ff, rate_in, y_ff, y_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [32:0]       dp11_ff, dp11_in;
   logic signed [OPA_W-1:0]  inner_ff, inner_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [WIDE_W-1:0] prod_wide, rnd_dt, rnd_cov, rnd_sel, tgt_val, upd_sum;
   logic signed [31:0]       upd_res;
   logic signed [33:0]       s_sum;
   logic                     div_busy;
   logic signed [31:0]       div_quo;

   // select multiplier operands
   always_comb begin
      case (cmd.a_sel)
         SA_RATE:  op_a = OPA_W'(rate_ff);
         SA_P11:   op_a = OPA_W'(p11_ff);
         SA_INNER: op_a = inner_ff;
         SA_QB:    op_a = OPA_W'(signed'({1'b0, qb_ff}));
         SA_K0:    op_a = OPA_W'(k0_ff);
         SA_K1:    op_a = OPA_W'(k1_ff);
         default:  op_a = '0;
      endcase
      case (cmd.b_sel)
         SB_DT:   op_b = OPB_W'(signed'({1'b0, dt_ff}));
         SB_Y:    op_b = OPB_W'(y_ff);
         SB_P00:  op_b = OPB_W'(p00_ff);
         SB_P01:  op_b = OPB_W'(p01_ff);
         default: op_b = '0;
      endcase
   end

   // round the registered product and fold it into the target
   always_comb begin
      prod_wide = WIDE_W'(prod_ff);
      rnd_dt    = (prod_wide + HALF_DT) >>> DT_FRAC;
      rnd_cov   = (prod_wide + HALF_COV) >>> COV_FRAC_BITS;
      rnd_sel   = cmd.cov_shift ? rnd_cov : rnd_dt;
      case (cmd.tgt)
         TG_ANGLE: tgt_val = WIDE_W'(angle_ff);
         TG_BIAS:  tgt_val = WIDE_W'(bias_ff);
         TG_P00:   tgt_val = WIDE_W'(p00_ff);
         TG_P01:   tgt_val = WIDE_W'(p01_ff);
         TG_P10:   tgt_val = WIDE_W'(p10_ff);
         TG_P11:   tgt_val = WIDE_W'(p11_ff);
         default:  tgt_val = '0;
      endcase
      upd_sum = cmd.sub ? (tgt_val - rnd_sel) : (tgt_val + rnd_sel);
      upd_res = sat32(upd_sum);
      s_sum   = 34'(p00_ff) + 34'(signed'({1'b0, r_ff}));
   end

   abkf_div #(
      .COV_FRAC_BITS(COV_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd_valid && cmd.op == OP_DIV),
      .num   (cmd.gain_sel ? p10_ff : p00_ff),
      .den   (s_sum[32:0]),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // next-state of all registers
   always_comb begin
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      r_in         = r_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      accel_in     = accel_ff;
      dt_in        = dt_ff;
      rate_in      = rate_ff;
      y_in         = y_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      dp11_in      = dp11_ff;
      inner_in     = inner_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // write noise registers, drop unknown indexes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_Q_ANGLE:   qa_in = csr_wdata;
            CSR_Q_BIAS:    qb_in = csr_wdata;
            CSR_R_MEASURE: r_in  = csr_wdata;
            default: ;
         endcase
      end

      // release the output word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd_valid) begin
         case (cmd.op)
            OP_LOAD: begin
               accel_in = req_data.tilt_meas;
               dt_in    = req_data.dt;
               rate_in  = sat32(WIDE_W'(req_data.spin_rate) - WIDE_W'(bias_ff));
            end
            OP_MUL: prod_in = PROD_W'(op_a) * PROD_W'(op_b);
            OP_UPD: begin
               case (cmd.tgt)
                  TG_ANGLE: angle_in = upd_res;
                  TG_BIAS:  bias_in  = upd_res;
                  TG_P00:   p00_in   = upd_res;
                  TG_P01:   p01_in   = upd_res;
                  TG_P10:   p10_in   = upd_res;
                  TG_P11:   p11_in   = upd_res;
                  default: ;
               endcase
            end
            OP_DP11: dp11_in = rnd_dt[32:0];
            OP_INNER: begin
               inner_in = OPA_W'(dp11_ff) - OPA_W'(p01_ff) - OPA_W'(p10_ff)
                          + OPA_W'(signed'({1'b0, qa_ff}));
               p01_in   = sat32(WIDE_W'(p01_ff) - WIDE_W'(dp11_ff));
               p10_in   = sat32(WIDE_W'(p10_ff) - WIDE_W'(dp11_ff));
            end
            OP_DIV: begin
               if (!cmd.gain_sel) begin
                  y_in = sat32(WIDE_W'(accel_ff) - WIDE_W'(angle_ff));
               end
            end
            OP_GAIN: begin
               if (cmd.gain_sel) begin
                  k1_in = div_quo;
               end else begin
                  k0_in = div_quo;
               end
            end
            OP_EMIT: begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.angle_est = angle_ff;
               rsp_data_in.bias_est  = bias_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff        <= Q_ANGLE_RST;
         qb_ff        <= Q_BIAS_RST;
         r_ff         <= R_MEASURE_RST;
         angle_ff     <= '0;
         bias_ff      <= '0;
         p00_ff       <= COV_ONE;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= COV_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         qa_ff        <= qa_in;
         qb_ff        <= qb_in;
         r_ff         <= r_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      accel_ff    <= accel_in;
      dt_ff       <= dt_in;
      rate_ff     <= rate_in;
      y_ff        <= y_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      dp11_ff     <= dp11_in;
      inner_ff    <= inner_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.gain_ok  = !s_sum[33] && (s_sum != '0);
   assign stat.div_done = !div_busy;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

`ifndef ASSERT_OFF
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd_valid && cmd.op == OP_EMIT))
      else $error("output word raised without an emit command");
`endif

endmodule
`default_nettype wire

>>> rtl/core/abkf_ctl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_ctl: filter sequencer
// Accepts a sample word, steps the datapath through predict, then gain and
// correct if P00 + R is positive, waits on the divider, hands the result to the output register.
// ----------------------------------------------------------------------------
module abkf_ctl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   output      abkf_pkg::cmd_type  cmd,
   output      logic               cmd_valid,
   input  wire abkf_pkg::stat_type stat
);
   import abkf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DIV  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   cmd_type           cur;

   // issue the current step, advance or hold
   always_comb begin
      cur       = prog_word(step_ff);
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = cur;
      cmd_valid = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd       = prog_word(STEP_LOAD);
            if (req_valid) begin
               cmd_valid = 1'b1;
               state_in  = S_RUN;
               step_in   = STEP_LOAD + 1'b1;
            end
         end
         S_RUN: begin
            if (cur.op == OP_DIV && !cur.gain_sel && !stat.gain_ok) begin
               // no usable innovation variance: skip gain and correction
               step_in = STEP_EMIT;
            end else if (cur.op == OP_EMIT) begin
               if (stat.out_free) begin
                  cmd_valid = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               cmd_valid = 1'b1;
               step_in   = step_ff + 1'b1;
               if (cur.op == OP_DIV) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_LOAD;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd.op == OP_EMIT) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after emit");
   a_quiet_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !cmd_valid)
      else $error("command issued while divider runs");
`endif

endmodule
`default_nettype wire

>>> rtl/core/angle_bias_kalman_filter_unit.sv
// The result of an accepted word goes through predict, gain and correct; when P00 plus
// the measurement noise is not positive, gain and correction are skipped.
// A new word is taken only after the result of the last one has gone to the output
// register; a stalled result holds off the next word.
// The bit-serial gain divider runs once per gain; the skip path does not run it.
// Reset: synchronous; angle and bias clear, P returns to identity, noise regs to defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_unit: one-axis angle / gyro-bias Kalman filter
// Fuses an accelerometer angle with a gyro rate per sample and returns the
// filtered angle and the estimated bias.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_unit #(
   parameter int COV_FRAC_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [1:0]             csr_index,
   input  wire logic [24:0]            csr_wdata,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire abkf_pkg::req_word_type req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      abkf_pkg::rsp_word_type rsp_data
);
   import abkf_pkg::*;

   cmd_type  cmd;
   logic     cmd_valid;
   stat_type stat;

   abkf_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .stat      (stat)
   );

   abkf_dp #(
      .COV_FRAC_BITS(COV_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
